// ===== sv/aesm_pkg.sv =====
// shared types, constants and functions for the aes-128 modes unit
package aesm_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    CFG_KEY_HIGH = 3'd0,
    CFG_KEY_LOW  = 3'd1,
    CFG_IV_HIGH  = 3'd2,
    CFG_IV_LOW   = 3'd3,
    CFG_MODE     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_ENC    = 2'd0,
    REQ_DEC    = 2'd1,
    REQ_RELOAD = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CFB = 2'd2,
    MODE_RSV = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  typedef struct packed {
    req_t        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } cipher_req_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        error_code;
  } cipher_res_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] sbox_rev(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block is bits 127-8i
  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t, o;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = sbox(gb(s, r + 4*((c+r)%4)));
      end
    end
    o = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = gb(t, 4*c); a1 = gb(t, 4*c+1); a2 = gb(t, 4*c+2); a3 = gb(t, 4*c+3);
        o[127-8*(4*c) -: 8]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] dec_pre(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*((c+r)%4)) -: 8] = sbox_rev(gb(s, r + 4*c));
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = gb(s, 4*c+k);
        x2[k] = xt(a[k]); x4[k] = xt(x2[k]); x8[k] = xt(x4[k]);
        m9[k] = x8[k] ^ a[k];
        mb[k] = x8[k] ^ x2[k] ^ a[k];
        md[k] = x8[k] ^ x4[k] ^ a[k];
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      o[127-8*(4*c) -: 8]   = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      o[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      o[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      o[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return o;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== sv/aesm_if.sv =====
// valid/ready channel carrying a payload
interface aesm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/aesm_key_ram.sv =====
// round key memory, 128-bit words, one write and one registered read port
module aesm_key_ram #(
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [127:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [127:0]             rdata
);
  logic [127:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/aes128_block_cipher_modes_unit.sv =====
// aes-128 ecb/cbc/cfb unit: top level with control, datapath and chaining
//
//  channel | dir | payload                        | handshake
//  in      | in  | req_type, block_high/low       | valid/ready
//  out     | out | out_high/low, error_code       | valid/ready
//  cfg     | in  | cfg_we, cfg_idx, cfg_data      | write enable
//
// an encrypt or decrypt request runs these steps after acceptance: key read in the
// accepting cycle, eleven round steps (key addition, ten rounds), an output step that
// waits for room on out; a new request is taken only back in idle. reload, no-key and
// ignored requests leave the control idle. a key write stores round key 0 and starts
// the expansion, requests held off. reset clears control and chain. with a key loaded,
// the next request is taken while a finished result waits on out.
module aes128_block_cipher_modes_unit #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  aesm_if.sink                              in_ch,
  aesm_if.source                            out_ch,
  input  logic                              cfg_we,
  input  logic [aesm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [aesm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int unsigned NK = ROUND_COUNT + 1;
  localparam int unsigned AW = $clog2(NK);

  aesm_pkg::state_t st_r, st_nxt;
  logic [63:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r, chain_hi_r, chain_lo_r;
  logic [1:0]  mode_r;
  logic        key_loaded_r;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [127:0] kexp_r;
  logic [7:0]   rcon_r;
  logic [127:0] st_blk_r, st_blk_nxt;
  logic [127:0] blk_in_r;
  logic         dec_r;
  logic         ovalid_r;
  logic [127:0] odata_r;
  logic         oerr_r;

  logic         kwe;
  logic [AW-1:0] kwaddr, kraddr;
  logic [127:0] kwdata, krdata;
  logic         kstart;
  logic [127:0] new_key;
  logic         cfb, fwd;
  logic         out_free;
  logic         finish;
  logic         err_now;
  logic [127:0] fin_res;
  logic [127:0] xin, pre;
  logic         load_now;

  aesm_key_ram #(.DEPTH(NK)) u_ram (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata),
    .raddr(kraddr), .rdata(krdata)
  );

  assign kstart = cfg_we && (cfg_idx == aesm_pkg::CFG_KEY_HIGH ||
                             cfg_idx == aesm_pkg::CFG_KEY_LOW);
  assign new_key = (cfg_idx == aesm_pkg::CFG_KEY_HIGH) ? {cfg_data, key_lo_r}
                                                       : {key_hi_r, cfg_data};
  assign out_free = !ovalid_r || out_ch.ready;
  assign cfb = (mode_r == aesm_pkg::MODE_CFB);
  assign fwd = cfb || !dec_r;
  assign in_ch.ready = (st_r == aesm_pkg::ST_IDLE) && (out_free || key_loaded_r) && !kstart;
  assign err_now = in_ch.valid && in_ch.ready && !key_loaded_r &&
                   (in_ch.data.req_type inside {aesm_pkg::REQ_ENC, aesm_pkg::REQ_DEC});

  // key expansion writes: round 0 on the key write, others from kexp_r
  always_comb begin
    kwe = 1'b0;
    kwaddr = cnt_r;
    kwdata = aesm_pkg::key_next(kexp_r, rcon_r);
    if (st_r == aesm_pkg::ST_KEXP) begin
      kwe = 1'b1;
      kwaddr = AW'(cnt_r + AW'(1));
    end
    if (kstart) begin
      kwe = 1'b1;
      kwaddr = '0;
      kwdata = new_key;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    st_blk_nxt = st_blk_r;
    finish = 1'b0;
    load_now = 1'b0;
    kraddr = cnt_r;
    pre = '0;
    case (st_r)
      aesm_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready && key_loaded_r &&
            (in_ch.data.req_type == aesm_pkg::REQ_ENC ||
             in_ch.data.req_type == aesm_pkg::REQ_DEC)) begin
          load_now = 1'b1;
          st_nxt = aesm_pkg::ST_LOAD;
          kraddr = (in_ch.data.req_type == aesm_pkg::REQ_DEC &&
                    mode_r != aesm_pkg::MODE_CFB) ? AW'(ROUND_COUNT) : '0;
          cnt_nxt = kraddr;
        end
      end
      aesm_pkg::ST_KEXP: begin
        cnt_nxt = AW'(cnt_r + AW'(1));
        if (cnt_r == AW'(ROUND_COUNT - 1)) st_nxt = aesm_pkg::ST_IDLE;
      end
      aesm_pkg::ST_LOAD: begin
        // initial key addition
        st_blk_nxt = xin ^ krdata;
        cnt_nxt = fwd ? AW'(cnt_r + AW'(1)) : AW'(cnt_r - AW'(1));
        kraddr = cnt_nxt;
        st_nxt = aesm_pkg::ST_ROUND;
      end
      aesm_pkg::ST_ROUND: begin
        if (fwd) begin
          st_blk_nxt = aesm_pkg::enc_round(st_blk_r, cnt_r == AW'(ROUND_COUNT)) ^ krdata;
        end else begin
          pre = aesm_pkg::dec_pre(st_blk_r) ^ krdata;
          st_blk_nxt = (cnt_r == '0) ? pre : aesm_pkg::inv_mix(pre);
        end
        if ((fwd && cnt_r == AW'(ROUND_COUNT)) || (!fwd && cnt_r == '0)) begin
          st_nxt = aesm_pkg::ST_DONE;
        end else begin
          cnt_nxt = fwd ? AW'(cnt_r + AW'(1)) : AW'(cnt_r - AW'(1));
          kraddr = cnt_nxt;
        end
      end
      aesm_pkg::ST_DONE: begin
        if (out_free) begin
          finish = 1'b1;
          st_nxt = aesm_pkg::ST_IDLE;
        end
      end
      default: st_nxt = aesm_pkg::ST_IDLE;
    endcase
    if (kstart) begin
      st_nxt = aesm_pkg::ST_KEXP;
      cnt_nxt = '0;
    end
  end

  // cipher input selection by mode
  always_comb begin
    xin = blk_in_r;
    case (mode_r)
      aesm_pkg::MODE_CBC: xin = dec_r ? blk_in_r : blk_in_r ^ {chain_hi_r, chain_lo_r};
      aesm_pkg::MODE_CFB: xin = {chain_hi_r, chain_lo_r};
      default: xin = blk_in_r;
    endcase
  end

  always_comb begin
    fin_res = st_blk_r;
    case (mode_r)
      aesm_pkg::MODE_CBC: fin_res = dec_r ? st_blk_r ^ {chain_hi_r, chain_lo_r} : st_blk_r;
      aesm_pkg::MODE_CFB: fin_res = st_blk_r ^ blk_in_r;
      default: fin_res = st_blk_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= aesm_pkg::ST_IDLE;
      cnt_r <= '0;
      key_loaded_r <= 1'b0;
      ovalid_r <= 1'b0;
      mode_r <= aesm_pkg::MODE_ECB;
      chain_hi_r <= '0;
      chain_lo_r <= '0;
      iv_hi_r <= '0;
      iv_lo_r <= '0;
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      st_blk_r <= st_blk_nxt;
      if (kstart) begin
        kexp_r <= new_key;
        rcon_r <= 8'h01;
      end else if (st_r == aesm_pkg::ST_KEXP) begin
        kexp_r <= kwdata;
        rcon_r <= aesm_pkg::xt(rcon_r);
      end
      if (load_now) begin
        blk_in_r <= {in_ch.data.block_high, in_ch.data.block_low};
        dec_r <= (in_ch.data.req_type == aesm_pkg::REQ_DEC);
      end
      if (in_ch.valid && in_ch.ready && in_ch.data.req_type == aesm_pkg::REQ_RELOAD) begin
        chain_hi_r <= iv_hi_r;
        chain_lo_r <= iv_lo_r;
      end
      if (finish) begin
        ovalid_r <= 1'b1;
        odata_r <= fin_res;
        oerr_r <= 1'b0;
        if (mode_r == aesm_pkg::MODE_CBC) begin
          {chain_hi_r, chain_lo_r} <= dec_r ? blk_in_r : fin_res;
        end else if (mode_r == aesm_pkg::MODE_CFB) begin
          {chain_hi_r, chain_lo_r} <= dec_r ? blk_in_r : fin_res;
        end
      end else if (err_now) begin
        ovalid_r <= 1'b1;
        odata_r <= '0;
        oerr_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          aesm_pkg::CFG_KEY_HIGH: begin
            key_hi_r <= cfg_data;
            key_loaded_r <= 1'b1;
          end
          aesm_pkg::CFG_KEY_LOW: begin
            key_lo_r <= cfg_data;
            key_loaded_r <= 1'b1;
          end
          aesm_pkg::CFG_IV_HIGH: begin
            iv_hi_r <= cfg_data;
            chain_hi_r <= cfg_data;
          end
          aesm_pkg::CFG_IV_LOW: begin
            iv_lo_r <= cfg_data;
            chain_lo_r <= cfg_data;
          end
          aesm_pkg::CFG_MODE: mode_r <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data.out_high = odata_r[127:64];
  assign out_ch.data.out_low = odata_r[63:0];
  assign out_ch.data.error_code = oerr_r;
endmodule

// ===== tb/tb_aes128_block_cipher_modes_unit.sv =====
// self-checking testbench for the aes-128 ecb/cbc/cfb modes unit
`timescale 1ns / 100ps

module tb_aes128_block_cipher_modes_unit;

  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [aesm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [aesm_pkg::CFG_DATA_W-1:0] cfg_data;

  aesm_if #(.payload_t(aesm_pkg::cipher_req_t)) in_ch (clk);
  aesm_if #(.payload_t(aesm_pkg::cipher_res_t)) out_ch (clk);

  aes128_block_cipher_modes_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  aesm_pkg::cipher_req_t pending_reqs[$];
  aesm_pkg::cipher_res_t expected_blocks[$];
  int unsigned fail_count = 0;
  bit calm = 0;
  bit hold_sender = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned quiet_cycles = 0;

  // predictor state
  logic [7:0]   fwd_box [256];
  logic [7:0]   rev_box [256];
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [1:0]   mode_r;
  logic [127:0] chain_r;
  logic [127:0] sched [11];
  bit           have_key;

  always #6 clk = ~clk;

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  function automatic void build_boxes();
    logic [7:0] inv, p, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      p = x[7:0];
      for (int e = 254; e != 0; e >>= 1) begin
        if (e & 1) inv = gf_mul(inv, p);
        p = gf_mul(p, p);
      end
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_box[x] = s;
      rev_box[s] = x[7:0];
    end
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  function automatic void expand_schedule();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] rc, t0;
    logic [127:0] k;
    rc = 8'h01;
    k = {key_hi_r, key_lo_r};
    for (int i = 0; i < 16; i++) w[i] = byte_at(k, i);
    for (int i = 4; i < 44; i++) begin
      for (int p = 0; p < 4; p++) t[p] = w[4*(i-1)+p];
      if (i % 4 == 0) begin
        t0 = t[0];
        t[0] = fwd_box[t[1]] ^ rc;
        t[1] = fwd_box[t[2]];
        t[2] = fwd_box[t[3]];
        t[3] = fwd_box[t0];
        rc = dbl(rc);
      end
      for (int p = 0; p < 4; p++) w[4*i+p] = w[4*(i-4)+p] ^ t[p];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) sched[r][127-8*i -: 8] = w[16*r+i];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inv) t[127-8*(r+4*((c+r)%4)) -: 8] = rev_box[byte_at(s, r+4*c)];
        else t[127-8*(r+4*c) -: 8] = fwd_box[byte_at(s, r+4*((c+r)%4))];
      end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input bit inv);
    logic [7:0] m [4];
    logic [7:0] acc;
    logic [127:0] o;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(m[(k-r+4)%4], byte_at(s, 4*c+k));
        o[127-8*(4*c+r) -: 8] = acc;
      end
    return o;
  endfunction

  function automatic logic [127:0] aes_block(input logic [127:0] s, input bit dec);
    if (!dec) begin
      s ^= sched[0];
      for (int r = 1; r < 10; r++) s = mix(sub_shift(s, 0), 0) ^ sched[r];
      s = sub_shift(s, 0) ^ sched[10];
    end else begin
      s ^= sched[10];
      for (int r = 9; r >= 1; r--) s = mix(sub_shift(s, 1) ^ sched[r], 1);
      s = sub_shift(s, 1) ^ sched[0];
    end
    return s;
  endfunction

  function automatic void predict_request(input aesm_pkg::cipher_req_t q);
    logic [127:0] blk, res, ks;
    bit dec;
    blk = {q.block_high, q.block_low};
    dec = (q.req_type == aesm_pkg::REQ_DEC);
    if (q.req_type == aesm_pkg::REQ_NONE) return;
    if (q.req_type == aesm_pkg::REQ_RELOAD) begin
      chain_r = {iv_hi_r, iv_lo_r};
      return;
    end
    if (!have_key) begin
      expected_blocks.push_back('{64'd0, 64'd0, 1'b1});
      return;
    end
    case (mode_r)
      aesm_pkg::MODE_CBC: begin
        if (!dec) begin
          res = aes_block(blk ^ chain_r, 0);
          chain_r = res;
        end else begin
          res = aes_block(blk, 1) ^ chain_r;
          chain_r = blk;
        end
      end
      aesm_pkg::MODE_CFB: begin
        ks = aes_block(chain_r, 0);
        res = blk ^ ks;
        chain_r = dec ? blk : res;
      end
      default: res = aes_block(blk, dec);
    endcase
    expected_blocks.push_back('{res[127:64], res[63:0], 1'b0});
  endfunction

  task automatic settle();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    case (idx)
      aesm_pkg::CFG_KEY_HIGH: begin key_hi_r = v; expand_schedule(); have_key = 1; end
      aesm_pkg::CFG_KEY_LOW:  begin key_lo_r = v; expand_schedule(); have_key = 1; end
      aesm_pkg::CFG_IV_HIGH:  begin iv_hi_r = v; chain_r[127:64] = v; end
      aesm_pkg::CFG_IV_LOW:   begin iv_lo_r = v; chain_r[63:0] = v; end
      aesm_pkg::CFG_MODE:     mode_r = v[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_req(input aesm_pkg::req_t t, input logic [63:0] h,
                                    input logic [63:0] l);
    pending_reqs.push_back('{t, h, l});
  endfunction

  function automatic void queue_random(input int n);
    aesm_pkg::req_t t;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 44) t = aesm_pkg::REQ_ENC;
      else if (pick < 88) t = aesm_pkg::REQ_DEC;
      else if (pick < 96) t = aesm_pkg::REQ_RELOAD;
      else t = aesm_pkg::REQ_NONE;
      queue_req(t, rand_word(), rand_word());
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_request(in_ch.data);
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 12) - 1;
        in_ch.valid <= 1'b0;
      end else if (!hold_sender && pending_reqs.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_reqs.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    aesm_pkg::cipher_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      quiet_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected result out_high=%h out_low=%h", out_ch.data.out_high,
                 out_ch.data.out_low);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_ch.data.out_high !== want.out_high) begin
            $error("out_high expected %h got %h", want.out_high, out_ch.data.out_high);
            fail_count++;
          end
          if (out_ch.data.out_low !== want.out_low) begin
            $error("out_low expected %h got %h", want.out_low, out_ch.data.out_low);
            fail_count++;
          end
          if (out_ch.data.error_code !== want.error_code) begin
            $error("error_code expected %0d got %0d", want.error_code,
                   out_ch.data.error_code);
            fail_count++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
        $display("aes128_block_cipher_modes_unit verification failed");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    key_hi_r = '0; key_lo_r = '0; iv_hi_r = '0; iv_lo_r = '0;
    mode_r = aesm_pkg::MODE_ECB;
    chain_r = '0;
    have_key = 0;
    build_boxes();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no key yet
    queue_req(aesm_pkg::REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_req(aesm_pkg::REQ_DEC, '1, '1);
    queue_req(aesm_pkg::REQ_RELOAD, '0, '0);
    queue_req(aesm_pkg::REQ_NONE, '1, '0);
    settle();

    write_reg(aesm_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
    write_reg(aesm_pkg::CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    write_reg(CFG_UNUSED_IDX, '1);
    queue_req(aesm_pkg::REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_req(aesm_pkg::REQ_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_req(aesm_pkg::REQ_ENC, '0, '0);
    queue_req(aesm_pkg::REQ_DEC, '1, '1);
    settle();

    write_reg(aesm_pkg::CFG_IV_HIGH, 64'h0f0e0d0c0b0a0908);
    write_reg(aesm_pkg::CFG_IV_LOW, '1);
    write_reg(aesm_pkg::CFG_MODE, 64'(aesm_pkg::MODE_CBC));
    queue_req(aesm_pkg::REQ_ENC, 64'h1234, 64'h5678);
    queue_req(aesm_pkg::REQ_ENC, '1, '0);
    queue_req(aesm_pkg::REQ_RELOAD, '0, '0);
    queue_req(aesm_pkg::REQ_DEC, 64'hdeadbeef, 64'hcafe);
    queue_req(aesm_pkg::REQ_DEC, '0, '1);
    settle();

    write_reg(aesm_pkg::CFG_MODE, 64'(aesm_pkg::MODE_CFB));
    queue_req(aesm_pkg::REQ_ENC, '0, '0);
    queue_req(aesm_pkg::REQ_ENC, '1, '1);
    queue_req(aesm_pkg::REQ_RELOAD, '0, '0);
    queue_req(aesm_pkg::REQ_DEC, '0, '0);
    queue_req(aesm_pkg::REQ_NONE, '0, '0);
    settle();

    write_reg(aesm_pkg::CFG_MODE, 64'(aesm_pkg::MODE_RSV));
    queue_req(aesm_pkg::REQ_ENC, '1, '1);
    queue_req(aesm_pkg::REQ_DEC, '0, '0);
    queue_req(aesm_pkg::REQ_RELOAD, '1, '1);
    settle();

    for (int p = 0; p < 12; p++) begin
      if (p == 11) calm = 1;
      if (p % 3 == 0) begin
        write_reg(aesm_pkg::CFG_KEY_HIGH, rand_word());
        write_reg(aesm_pkg::CFG_KEY_LOW, rand_word());
      end
      write_reg(aesm_pkg::CFG_IV_HIGH, rand_word());
      write_reg(aesm_pkg::CFG_IV_LOW, rand_word());
      write_reg(aesm_pkg::CFG_MODE, 64'(p % 4));
      queue_random(45);
      if (p == 5) begin
        // sender holds until every result is back
        while (pending_reqs.size() > 20) @(posedge clk);
        hold_sender = 1;
        while (expected_blocks.size() != 0 || in_ch.valid) @(posedge clk);
        hold_sender = 0;
      end
      queue_random(45);
      settle();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("aes128_block_cipher_modes_unit verification clean");
    else
      $display("aes128_block_cipher_modes_unit verification failed");
    $finish;
  end

endmodule

// ===== aes128_block_cipher_modes_unit.f =====
sv/aesm_pkg.sv
sv/aesm_if.sv
sv/aesm_key_ram.sv
sv/aes128_block_cipher_modes_unit.sv
tb/tb_aes128_block_cipher_modes_unit.sv
